// ===== hdl/csd_pkg.sv =====
package csd_pkg;

    // Score field width and highest index the score field can address.
    localparam int SCORE_W   = 4;
    localparam int SCORE_TOP = (1 << SCORE_W) - 1;
    localparam int HIST_DEPTH = SCORE_TOP + 1;

    typedef logic [SCORE_W-1:0] t_score;

    typedef enum logic {
        ST_LOAD,
        ST_EMIT
    } t_state;

    typedef enum logic [1:0] {
        HOP_NONE,
        HOP_INC,
        HOP_DEC
    } t_hist_op;

    // Command to the histogram store: one entry, one op per cycle.
    typedef struct packed {
        t_hist_op op;
        t_score   idx;
    } t_hist_ctl;

endpackage

// ===== hdl/csd_if.sv =====
interface csd_in_if;
    logic                 valid;
    logic                 ready;
    logic [3:0]           score;
    logic                 final_item;

    modport source (output valid, output score, output final_item, input ready);
    modport sink   (input valid, input score, input final_item, output ready);
endinterface

interface csd_out_if;
    logic                 valid;
    logic                 ready;
    logic [3:0]           sorted_score;
    logic                 final_result;

    modport source (output valid, output sorted_score, output final_result, input ready);
    modport sink   (input valid, input sorted_score, input final_result, output ready);
endinterface

// ===== hdl/counting_sort_descending_unit.sv =====
// Flow: a score is counted in the cycle it is accepted; after the final score the
//   sequencer walks the histogram down from the top value into the output register.
// Emission yields the N beats and skips each empty value (at most
//   min(MAX_SCORE,15)), stalling on output back-pressure; no score is taken
//   until the walk through the histogram's single read port and add unit ends.
// Reset: synchronous, active low; clears histogram, counts, sequencer, output valid.
module counting_sort_descending_unit #(
    parameter int MAX_ITEMS = 32,
    parameter int MAX_SCORE = 15
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    csd_in_if.sink     i_in,
    csd_out_if.source  o_out
);

    // Count width holds MAX_ITEMS itself.
    localparam int CNT_W = $clog2(MAX_ITEMS + 1);
    // Highest histogram index that can ever be nonzero.
    localparam int TOP   = (MAX_SCORE > csd_pkg::SCORE_TOP) ? csd_pkg::SCORE_TOP : MAX_SCORE;
    localparam logic [csd_pkg::SCORE_W-1:0] TOP_IDX = csd_pkg::SCORE_W'(TOP);

    csd_pkg::t_state    r_state, n_state;
    csd_pkg::t_hist_ctl w_ctl;
    logic [CNT_W-1:0]   w_rd_count;

    logic [CNT_W-1:0]             r_count, n_count;   // scores loaded in this set
    logic [CNT_W-1:0]             r_rem,   n_rem;     // beats still to emit
    logic [csd_pkg::SCORE_W-1:0]  r_v,     n_v;       // walk pointer, high to low

    logic                         r_out_valid, n_out_valid;
    logic [csd_pkg::SCORE_W-1:0]  r_out_score, n_out_score;
    logic                         r_out_final, n_out_final;

    logic w_accept;
    logic w_take;      // accepted score gets counted
    logic w_emit_go;   // one sorted beat moves into the output register

    csd_hist #(
        .CNT_W (CNT_W)
    ) u_hist (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (w_ctl),
        .o_rd_count (w_rd_count)
    );

    assign i_in.ready = (r_state == csd_pkg::ST_LOAD);
    assign w_accept   = i_in.valid && i_in.ready;

    // out-of-range scores and scores past a full set are dropped
    assign w_take = w_accept
                 && (8'(i_in.score) <= 8'(MAX_SCORE))
                 && (r_count != CNT_W'(MAX_ITEMS));

    assign w_emit_go = (r_state == csd_pkg::ST_EMIT)
                    && (r_rem != '0)
                    && (w_rd_count != '0)
                    && (!r_out_valid || o_out.ready);

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            csd_pkg::ST_LOAD: begin
                if (w_accept && i_in.final_item) begin
                    n_state = csd_pkg::ST_EMIT;
                end
            end
            csd_pkg::ST_EMIT: begin
                if (r_rem == '0) begin
                    n_state = csd_pkg::ST_LOAD;
                end
            end
            default: begin
                n_state = csd_pkg::ST_LOAD;
            end
        endcase
    end

    // datapath and histogram commands
    always_comb begin
        w_ctl.op    = csd_pkg::HOP_NONE;
        w_ctl.idx   = r_v;
        n_count     = r_count;
        n_rem       = r_rem;
        n_v         = r_v;
        n_out_valid = r_out_valid;
        n_out_score = r_out_score;
        n_out_final = r_out_final;

        // output register drains independently of the sequencer
        if (o_out.ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            csd_pkg::ST_LOAD: begin
                w_ctl.idx = i_in.score;
                if (w_take) begin
                    w_ctl.op = csd_pkg::HOP_INC;
                    n_count  = r_count + CNT_W'(1);
                end
                if (w_accept && i_in.final_item) begin
                    n_rem   = n_count;
                    n_v     = TOP_IDX;
                    n_count = '0;
                end
            end
            csd_pkg::ST_EMIT: begin
                w_ctl.idx = r_v;
                if (w_emit_go) begin
                    // decrementing each entry leaves the histogram clear at the end
                    w_ctl.op    = csd_pkg::HOP_DEC;
                    n_rem       = r_rem - CNT_W'(1);
                    n_out_valid = 1'b1;
                    n_out_score = r_v;
                    n_out_final = (r_rem == CNT_W'(1));
                end else if ((r_rem != '0) && (w_rd_count == '0)) begin
                    n_v = r_v - csd_pkg::SCORE_W'(1);
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= csd_pkg::ST_LOAD;
            r_count     <= '0;
            r_rem       <= '0;
            r_v         <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_rem       <= n_rem;
            r_v         <= n_v;
            r_out_valid <= n_out_valid;
        end
    end

    // payload, no reset
    always_ff @(posedge i_clk) begin
        r_out_score <= n_out_score;
        r_out_final <= n_out_final;
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.sorted_score = r_out_score;
    assign o_out.final_result = r_out_final;

endmodule

// ===== hdl/csd_hist.sv =====
module csd_hist #(
    parameter int CNT_W = 6
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  csd_pkg::t_hist_ctl i_ctl,
    output logic [CNT_W-1:0]   o_rd_count
);

    logic [CNT_W-1:0] r_hist [csd_pkg::HIST_DEPTH];
    logic [CNT_W-1:0] w_step;
    logic [CNT_W-1:0] w_sum;

    assign o_rd_count = r_hist[i_ctl.idx];

    // single add unit: +1 on load, -1 (all ones) on emit
    assign w_step = (i_ctl.op == csd_pkg::HOP_DEC) ? {CNT_W{1'b1}} : CNT_W'(1);
    assign w_sum  = o_rd_count + w_step;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < csd_pkg::HIST_DEPTH; i++) begin
                r_hist[i] <= '0;
            end
        end else begin
            case (i_ctl.op)
                csd_pkg::HOP_INC,
                csd_pkg::HOP_DEC: begin
                    r_hist[i_ctl.idx] <= w_sum;
                end
                default: begin
                end
            endcase
        end
    end

endmodule

// ===== hdl/csd_checker.sv =====
module csd_checker #(
    parameter int MAX_ITEMS = 32
) (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_valid,
    input logic       i_in_ready,
    input logic       i_in_final_item,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic [3:0] i_out_score,
    input logic       i_out_final
);

    localparam int BEAT_W = $clog2(MAX_ITEMS + 2);

    logic              r_prev_final;
    logic [3:0]        r_prev_score;
    logic [BEAT_W-1:0] r_beats;
    logic              w_out_beat;

    assign w_out_beat = i_out_valid && i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_final <= 1'b1;
            r_prev_score <= '0;
            r_beats      <= '0;
        end else if (w_out_beat) begin
            r_prev_final <= i_out_final;
            r_prev_score <= i_out_score;
            r_beats      <= i_out_final ? '0 : r_beats + BEAT_W'(1);
        end
    end

    // stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=>
            i_out_valid && $stable(i_out_score) && $stable(i_out_final))
        else $error("stalled result changed");

    // within a set scores never rise
    a_descending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_out_beat && !r_prev_final |-> i_out_score <= r_prev_score)
        else $error("result order not descending");

    // a set never yields more beats than it can hold
    a_set_size: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_out_beat |-> r_beats < BEAT_W'(MAX_ITEMS))
        else $error("too many results in one set");

    // loading continues after a non-final score
    a_keep_loading: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready && !i_in_final_item |=> i_in_ready)
        else $error("input stalled during load");

endmodule

bind counting_sort_descending_unit csd_checker #(
    .MAX_ITEMS (MAX_ITEMS)
) u_csd_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_in_valid      (i_in.valid),
    .i_in_ready      (i_in.ready),
    .i_in_final_item (i_in.final_item),
    .i_out_valid     (o_out.valid),
    .i_out_ready     (o_out.ready),
    .i_out_score     (o_out.sorted_score),
    .i_out_final     (o_out.final_result)
);

// ===== sim/csd_sort_checker.sv =====
// Watches both channels of the sorter, keeps its own score histogram and
// compares every sorted beat against the expected descending sequence.
module csd_sort_checker #(
    parameter int MAX_ITEMS = 32,
    parameter int MAX_SCORE = 15
) (
    input  logic i_clk,
    input  logic i_rst_n,
    csd_in_if    i_score_ch,
    csd_out_if   i_sorted_ch,
    output int   o_mismatches,
    output int   o_outstanding,
    output int   o_sets,
    output int   o_sorted_beats,
    output int   o_dropped
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int TOP_SCORE =
        (MAX_SCORE < csd_pkg::SCORE_TOP) ? MAX_SCORE : csd_pkg::SCORE_TOP;

    typedef struct packed {
        csd_pkg::t_score score;
        logic            last;
    } t_sorted_beat;

    logic [6:0]   score_tally [csd_pkg::HIST_DEPTH];
    logic [6:0]   tally_total;
    t_sorted_beat sorted_due [$];

    task automatic clear_tally();
        foreach (score_tally[v]) score_tally[v] = '0;
        tally_total = '0;
    endtask

    // Count one score (or drop it if out of range or past a full set); on the
    // final beat queue the whole set, highest value first, with the mark on the very last beat.
    task automatic absorb_score(input csd_pkg::t_score score, input logic last);
        int           remaining;
        t_sorted_beat beat;
        if (int'(score) <= MAX_SCORE && int'(tally_total) < MAX_ITEMS) begin
            score_tally[score] = score_tally[score] + 7'd1;
            tally_total        = tally_total + 7'd1;
        end else begin
            o_dropped++;
        end
        if (last) begin
            remaining = int'(tally_total);
            for (int v = TOP_SCORE; v >= 0; v--) begin
                for (int c = 0; c < int'(score_tally[v]) && remaining > 0; c++) begin
                    remaining--;
                    beat.score = csd_pkg::t_score'(v);
                    beat.last  = (remaining == 0);
                    sorted_due.push_back(beat);
                end
            end
            o_sets++;
            clear_tally();
        end
    endtask

    task automatic check_sorted(input csd_pkg::t_score score, input logic last);
        t_sorted_beat due;
        if (sorted_due.size() == 0) begin
            o_mismatches++;
            $display("%0t: extra sorted beat: expected none, got score %0d last %0b",
                     $time, score, last);
        end else begin
            due = sorted_due.pop_front();
            o_sorted_beats++;
            if (due.score !== score || due.last !== last) begin
                o_mismatches++;
                $display("%0t: sorted beat mismatch: expected %0d/%0b, got %0d/%0b",
                         $time, due.score, due.last, score, last);
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            clear_tally();
            sorted_due.delete();
            o_mismatches   = 0;
            o_sets         = 0;
            o_sorted_beats = 0;
            o_dropped      = 0;
        end else begin
            // inputs first: output beats always belong to older sets
            if (i_score_ch.valid && i_score_ch.ready)
                absorb_score(i_score_ch.score, i_score_ch.final_item);
            if (i_sorted_ch.valid && i_sorted_ch.ready)
                check_sorted(i_sorted_ch.sorted_score, i_sorted_ch.final_result);
        end
        o_outstanding = sorted_due.size();
    end

endmodule

// ===== sim/counting_sort_descending_unit_test.sv =====
// Stimulus and verdict for the descending counting sorter. The checker beside
// the block does all prediction; this module only feeds score sets, throttles
// the sorted output and decides pass/fail.
module counting_sort_descending_unit_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_ITEMS    = 32;
    localparam int MAX_SCORE    = 15;
    localparam int RANDOM_BEATS = 320;
    // Worst case has full stalls on both sides plus the histogram walk
    // per set; this limit is many times that.
    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = 40;

    logic i_clk;
    logic i_rst_n;

    csd_in_if  in_ch();
    csd_out_if out_ch();

    counting_sort_descending_unit #(
        .MAX_ITEMS(MAX_ITEMS),
        .MAX_SCORE(MAX_SCORE)
    ) dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (in_ch),
        .o_out  (out_ch)
    );

    int mismatches;
    int outstanding;
    int sets_seen;
    int sorted_beats;
    int dropped;

    csd_sort_checker #(
        .MAX_ITEMS(MAX_ITEMS),
        .MAX_SCORE(MAX_SCORE)
    ) sort_check (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_score_ch    (in_ch),
        .i_sorted_ch   (out_ch),
        .o_mismatches  (mismatches),
        .o_outstanding (outstanding),
        .o_sets        (sets_seen),
        .o_sorted_beats(sorted_beats),
        .o_dropped     (dropped)
    );

    // Upper bound of the per-beat idle draw on each side; the stimulus
    // switches these per set so that some sets run back to back.
    int unsigned load_gap_max  = 0;
    int unsigned drain_stall_max = 0;
    int unsigned beats_sent    = 0;
    int unsigned beats_counted = 0;
    int unsigned cycle_count   = 0;

    // 12 ns clock
    initial i_clk = 1'b0;
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Run limit: only reached if the block hangs.
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("counting_sort_descending_unit test failed");
        $finish;
    end

    // Sorted-output side: before every beat draw a stall, hold ready low through
    // the stall, then keep it high until a beat is taken. With a zero draw ready
    // simply stays high.
    initial begin
        int unsigned stall;
        out_ch.ready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            stall = $urandom_range(0, drain_stall_max);
            @(negedge i_clk);
            if (stall > 0) begin
                out_ch.ready <= 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            out_ch.ready <= 1'b1;
            @(posedge i_clk);
            while (!(out_ch.valid && out_ch.ready)) @(posedge i_clk);
        end
    end

    // One score beat: optional idle gap, then hold valid until accepted.
    // Valid is only lowered when a gap is drawn, so back-to-back beats never
    // see a low/high pair in the same step.
    task automatic send_score(input csd_pkg::t_score score, input logic last,
                              input bit counts);
        int unsigned gap;
        gap = $urandom_range(0, load_gap_max);
        @(negedge i_clk);
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        in_ch.valid      <= 1'b1;
        in_ch.score      <= score;
        in_ch.final_item <= last;
        @(posedge i_clk);
        while (!(in_ch.valid && in_ch.ready)) @(posedge i_clk);
        beats_sent++;
        if (counts) beats_counted++;
    endtask

    // Random set: its length decides whether the set fills up (the tail past
    // MAX_ITEMS is dropped by the block), and the score spread decides how
    // many duplicates land in one histogram bin.
    task automatic send_random_set();
        int unsigned     len;
        int unsigned     spread;
        int unsigned     lo;
        int unsigned     hi;
        csd_pkg::t_score score;
        case ($urandom_range(0, 9))
            0:       len = $urandom_range(MAX_ITEMS + 1, MAX_ITEMS + 12);
            1:       len = MAX_ITEMS;
            2, 3:    len = $urandom_range(13, MAX_ITEMS - 1);
            default: len = $urandom_range(1, 12);
        endcase
        spread = $urandom_range(0, 2);
        lo     = $urandom_range(0, csd_pkg::SCORE_TOP);
        hi     = (lo + 2 > csd_pkg::SCORE_TOP) ? csd_pkg::SCORE_TOP : lo + 2;
        for (int i = 0; i < len; i++) begin
            case (spread)
                0:       score = csd_pkg::t_score'($urandom_range(0, csd_pkg::SCORE_TOP));
                1:       score = csd_pkg::t_score'($urandom_range(lo, hi));
                default: score = ($urandom_range(0, 1) != 0) ?
                                 csd_pkg::t_score'(csd_pkg::SCORE_TOP) : '0;
            endcase
            send_score(score, i == len - 1, i < MAX_ITEMS);
        end
    endtask

    initial begin
        in_ch.valid      = 1'b0;
        in_ch.score      = '0;
        in_ch.final_item = 1'b0;
        i_rst_n          = 1'b0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // --- directed sets, no idling ---
        // single highest score, single lowest score
        send_score(csd_pkg::t_score'(csd_pkg::SCORE_TOP), 1'b1, 1'b1);
        send_score('0, 1'b1, 1'b1);
        // one bin holding several copies
        for (int i = 0; i < 4; i++) send_score(csd_pkg::t_score'(5), i == 3, 1'b1);

        // every value once, fed in ascending order, with idling on both sides
        load_gap_max    = 12;
        drain_stall_max = 12;
        for (int v = 0; v <= csd_pkg::SCORE_TOP; v++)
            send_score(csd_pkg::t_score'(v), v == csd_pkg::SCORE_TOP, 1'b1);

        // --- random sets ---
        // pacing per set: none, either side alone, or both sides idling
        while (beats_sent < RANDOM_BEATS) begin
            case ($urandom_range(0, 3))
                0: begin load_gap_max = 0;  drain_stall_max = 0;  end
                1: begin load_gap_max = 12; drain_stall_max = 0;  end
                2: begin load_gap_max = 0;  drain_stall_max = 12; end
                default: begin load_gap_max = 12; drain_stall_max = 12; end
            endcase
            send_random_set();
        end

        @(negedge i_clk);
        in_ch.valid <= 1'b0;

        // let every expected sorted beat come out, then watch a little longer
        // for stray beats
        while (outstanding != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);

        $display("Sent %0d score beats (%0d counted) in %0d sets, %0d dropped.",
                 beats_sent, beats_counted, sets_seen, dropped);
        $display("Checked %0d sorted beats against the expected descending order.",
                 sorted_beats);
        if (mismatches == 0 && outstanding == 0) begin
            $display("counting_sort_descending_unit test passed");
        end else begin
            $display("counting_sort_descending_unit test failed");
        end
        $finish;
    end

endmodule

// ===== files.f =====
hdl/csd_pkg.sv
hdl/csd_if.sv
hdl/csd_hist.sv
hdl/counting_sort_descending_unit.sv
hdl/csd_checker.sv
sim/csd_sort_checker.sv
sim/counting_sort_descending_unit_test.sv
